// ===== sv/plar_pkg.sv =====
// ----------------------------------------------------------------------------
// plar_pkg: shared types and constants of the polyline arc-length resampler
// Holds the coordinate and length widths, the segment command that the front
// end hands to the back end, and the lane types of the shared divider.
// ----------------------------------------------------------------------------
package plar_pkg;

  localparam int COORD_W     = 24;               // vertex and sample coordinates
  localparam int SPACE_W     = 16;               // sample spacing, 8 fraction bits
  localparam int LEN_W       = COORD_W + 1;      // floor of segment length
  localparam int PROD_W      = COORD_W + SPACE_W;
  localparam int DIVD_W      = PROD_W + 1;       // product plus half a length
  localparam int NUM_LANES   = 3;
  localparam int MAX_SEG     = 31;               // samples kept per segment
  localparam int CNT_W       = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SPACE_W-1:0] SPACING_RESET = SPACE_W'(10 << 8);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPACING  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = CFG_IDX_W'(2);

  // one unit of back-end work: a start point or a straight segment
  typedef struct packed {
    logic                      is_start;  // emit to_x/to_y itself
    logic                      ends;      // last command of its vertex
    logic signed [COORD_W-1:0] from_x;
    logic signed [COORD_W-1:0] from_y;
    logic signed [COORD_W-1:0] to_x;
    logic signed [COORD_W-1:0] to_y;
  } cmd_t;

  typedef struct packed {
    logic [DIVD_W-1:0] dividend;
    logic [LEN_W-1:0]  divisor;
  } div_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] quot;
    logic [LEN_W-1:0] rem;
  } div_out_t;

endpackage

// ===== sv/plar_front.sv =====
// ----------------------------------------------------------------------------
// plar_front: vertex intake
// Takes one vertex, tracks the previous vertex and subpath origin, and turns
// the vertex into one or two commands for the back end.
// ----------------------------------------------------------------------------
module plar_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [plar_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [plar_pkg::COORD_W-1:0]  vertex_y,
  input  logic                                 starts_subpath,
  input  logic                                 closes_subpath,
  output logic                                 push,
  output plar_pkg::cmd_t                       push_cmd,
  input  logic                                 q_full
);
  import plar_pkg::*;

  logic                      held;
  logic                      closing;   // second command (close) pending
  logic signed [COORD_W-1:0] hold_x, hold_y;
  logic                      hold_start, hold_close;
  logic signed [COORD_W-1:0] prev_x, prev_y, org_x, org_y;

  assign in_ready = !held;
  assign push     = held && !q_full;

  always_comb begin
    if (closing) begin
      push_cmd.is_start = 1'b0;
      push_cmd.ends     = 1'b1;
      push_cmd.from_x   = prev_x;
      push_cmd.from_y   = prev_y;
      push_cmd.to_x     = org_x;
      push_cmd.to_y     = org_y;
    end else begin
      push_cmd.is_start = hold_start;
      push_cmd.ends     = !hold_close;
      push_cmd.from_x   = hold_start ? hold_x : prev_x;
      push_cmd.from_y   = hold_start ? hold_y : prev_y;
      push_cmd.to_x     = hold_x;
      push_cmd.to_y     = hold_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      closing <= 1'b0;
      prev_x  <= '0;
      prev_y  <= '0;
      org_x   <= '0;
      org_y   <= '0;
    end else if (in_valid && in_ready) begin
      held    <= 1'b1;
      closing <= 1'b0;
    end else if (push) begin
      if (closing) begin
        prev_x  <= org_x;
        prev_y  <= org_y;
        held    <= 1'b0;
        closing <= 1'b0;
      end else begin
        prev_x <= hold_x;
        prev_y <= hold_y;
        if (hold_start) begin
          org_x <= hold_x;
          org_y <= hold_y;
        end
        if (hold_close) closing <= 1'b1;
        else held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_x     <= vertex_x;
      hold_y     <= vertex_y;
      hold_start <= starts_subpath;
      hold_close <= closes_subpath;
    end
  end

endmodule

// ===== sv/plar_queue.sv =====
// ----------------------------------------------------------------------------
// plar_queue: command queue
// Short first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
module plar_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  plar_pkg::cmd_t push_cmd,
  input  logic           pop,
  output plar_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import plar_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

endmodule

// ===== sv/plar_div.sv =====
// ----------------------------------------------------------------------------
// plar_div: multi-lane restoring divider
// Divides each lane's dividend by its divisor, one quotient bit a cycle. The
// upper dividend bits must be below the divisor; quotients are LEN_W bits.
// ----------------------------------------------------------------------------
module plar_div (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            start,
  input  plar_pkg::div_in_t  [plar_pkg::NUM_LANES-1:0]    lane_in,
  output logic                                            done,
  output plar_pkg::div_out_t [plar_pkg::NUM_LANES-1:0]    lane_out
);
  import plar_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(LEN_W - 1);

  logic             busy;
  logic [CNT_W-1:0] step;
  logic [LEN_W-1:0] rem   [NUM_LANES];
  logic [LEN_W-1:0] acc   [NUM_LANES];   // dividend bits in, quotient bits out
  logic [LEN_W-1:0] dvs   [NUM_LANES];
  logic [LEN_W:0]   trial [NUM_LANES];
  logic             fits  [NUM_LANES];

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      trial[i]             = {rem[i], acc[i][LEN_W-1]};
      fits[i]              = trial[i] >= {1'b0, dvs[i]};
      lane_out[i].quot     = acc[i];
      lane_out[i].rem      = rem[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (start) begin
        rem[i] <= LEN_W'(lane_in[i].dividend[DIVD_W-1:LEN_W]);
        acc[i] <= lane_in[i].dividend[LEN_W-1:0];
        dvs[i] <= lane_in[i].divisor;
      end else if (busy) begin
        rem[i] <= fits[i] ? LEN_W'(trial[i] - {1'b0, dvs[i]}) : trial[i][LEN_W-1:0];
        acc[i] <= {acc[i][LEN_W-2:0], fits[i]};
      end
    end
  end

endmodule

// ===== sv/plar_back.sv =====
// ----------------------------------------------------------------------------
// plar_back: segment sampler
// Measures each segment, divides out the first sample and the per-sample step
// on both axes, then walks the samples. One sample is held back until the
// next one or the end of the vertex shows whether it is the last.
// ----------------------------------------------------------------------------
module plar_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  plar_pkg::cmd_t                       head,
  input  logic                                 q_empty,
  output logic                                 pop,
  input  logic [plar_pkg::SPACE_W-1:0]         spacing,
  input  logic signed [plar_pkg::COORD_W-1:0]  centre_x,
  input  logic signed [plar_pkg::COORD_W-1:0]  centre_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [plar_pkg::COORD_W-1:0]  sample_x,
  output logic signed [plar_pkg::COORD_W-1:0]  sample_y,
  output logic                                 last_in_run,
  output logic                                 truncated
);
  import plar_pkg::*;

  localparam int SQ_W  = 2 * COORD_W;
  localparam int RAD_W = 2 * LEN_W;
  localparam int REM_W = LEN_W + 3;
  localparam int EXT_W = COORD_W + 2;
  localparam logic [CNT_W-1:0] LAST_ROOT = CNT_W'(LEN_W - 1);
  localparam logic signed [EXT_W-1:0] SAT_HI = $signed({3'b000, {(COORD_W-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] SAT_LO = $signed({3'b111, {(COORD_W-1){1'b0}}});

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQ    = 10'b0000000010,
    S_SUM   = 10'b0000000100,
    S_ROOT  = 10'b0000001000,
    S_PREP1 = 10'b0000010000,
    S_DIV1  = 10'b0000100000,
    S_PREP2 = 10'b0001000000,
    S_DIV2  = 10'b0010000000,
    S_EMIT  = 10'b0100000000,
    S_FLUSH = 10'b1000000000
  } state_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
    if (v > SAT_HI) return SAT_HI[COORD_W-1:0];
    if (v < SAT_LO) return SAT_LO[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  state_t              state;
  cmd_t                cmd;
  logic                neg_x, neg_y;
  logic [COORD_W-1:0]  ax, ay;
  logic [SQ_W-1:0]     sqx, sqy;
  logic [RAD_W-1:0]    rad;
  logic [REM_W-1:0]    rrem;
  logic [LEN_W-1:0]    root;
  logic [CNT_W-1:0]    rcnt;
  logic [PROD_W-1:0]   prodx, prody;
  logic [SPACE_W-1:0]  carried;
  logic [LEN_W-1:0]    q_x, r_x, q_y, r_y, sq_x, sr_x, sq_y, sr_y;
  logic                seg_trunc;
  logic [CNT_W-1:0]    emit_n, k;
  logic                div_run;
  logic                pend_valid, pend_trunc;
  logic [COORD_W-1:0]  pend_x, pend_y;

  // combinational
  logic [EXT_W-1:0]          dx, dy;
  logic [REM_W-1:0]          rem_sh, trial;
  logic [SPACE_W-1:0]        sp_eff, c_clamp, first;
  logic                      div_start, div_done;
  div_in_t  [NUM_LANES-1:0]  lane_in;
  div_out_t [NUM_LANES-1:0]  lane_out;
  logic signed [EXT_W-1:0]   off_x, off_y, pos_x, pos_y, val_x, val_y;
  logic                      can_place, place;
  logic [LEN_W:0]            rsum_x, rsum_y;

  assign dx     = EXT_W'(head.to_x) - EXT_W'(head.from_x);
  assign dy     = EXT_W'(head.to_y) - EXT_W'(head.from_y);
  assign rem_sh = {rrem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});

  assign sp_eff  = (spacing == '0) ? SPACE_W'(1) : spacing;
  assign c_clamp = (carried > sp_eff) ? sp_eff : carried;
  assign first   = sp_eff - c_clamp;

  assign pop       = (state == S_IDLE) && !q_empty;
  assign div_start = ((state == S_DIV1) || (state == S_DIV2)) && !div_run;

  always_comb begin
    if (state == S_DIV1) begin
      lane_in[0].dividend = DIVD_W'(prodx) + DIVD_W'(root >> 1);
      lane_in[1].dividend = DIVD_W'(prody) + DIVD_W'(root >> 1);
    end else begin
      lane_in[0].dividend = DIVD_W'(prodx);
      lane_in[1].dividend = DIVD_W'(prody);
    end
    lane_in[0].divisor  = root;
    lane_in[1].divisor  = root;
    lane_in[2].dividend = DIVD_W'(root - LEN_W'(first));
    lane_in[2].divisor  = LEN_W'(sp_eff);
  end

  plar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .lane_in  (lane_in),
    .done     (div_done),
    .lane_out (lane_out)
  );

  // sample point, then centre and saturate
  always_comb begin
    off_x  = neg_x ? -$signed(EXT_W'(q_x)) : $signed(EXT_W'(q_x));
    off_y  = neg_y ? -$signed(EXT_W'(q_y)) : $signed(EXT_W'(q_y));
    pos_x  = $signed(EXT_W'(cmd.from_x)) + off_x;
    pos_y  = $signed(EXT_W'(cmd.from_y)) + off_y;
    val_x  = pos_x - $signed(EXT_W'(centre_x));
    val_y  = pos_y - $signed(EXT_W'(centre_y));
    rsum_x = {1'b0, r_x} + {1'b0, sr_x};
    rsum_y = {1'b0, r_y} + {1'b0, sr_y};
  end

  assign can_place = !pend_valid || !out_valid || out_ready;
  assign place     = (state == S_EMIT) && can_place;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      carried    <= '0;
      div_run    <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (div_start) div_run <= 1'b1;
      if (div_done) div_run <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (head.is_start) begin
              carried <= '0;
              state   <= S_EMIT;
            end else begin
              state <= S_SQ;
            end
          end
        end
        S_SQ:  state <= S_SUM;
        S_SUM: state <= S_ROOT;
        S_ROOT: begin
          if (rcnt == LAST_ROOT) state <= S_PREP1;
        end
        S_PREP1: begin
          if (root == '0) begin
            state <= cmd.ends ? S_FLUSH : S_IDLE;
          end else if (root < LEN_W'(first)) begin
            // segment ends before the next sample: extend the carry
            carried <= c_clamp + root[SPACE_W-1:0];
            state   <= cmd.ends ? S_FLUSH : S_IDLE;
          end else begin
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            carried <= lane_out[2].rem[SPACE_W-1:0];
            state   <= S_PREP2;
          end
        end
        S_PREP2: state <= S_DIV2;
        S_DIV2: begin
          if (div_done) state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_place) begin
            pend_valid <= 1'b1;
            if (pend_valid) out_valid <= 1'b1;
            if (k == emit_n - 1'b1) state <= cmd.ends ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd   <= head;
      neg_x <= dx[EXT_W-1];
      neg_y <= dy[EXT_W-1];
      ax    <= dx[EXT_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
      ay    <= dy[EXT_W-1] ? COORD_W'(-dy) : COORD_W'(dy);
      if (head.is_start) begin
        q_x       <= '0;
        q_y       <= '0;
        seg_trunc <= 1'b0;
        emit_n    <= CNT_W'(1);
        k         <= '0;
      end
    end
    if (state == S_SQ) begin
      sqx <= SQ_W'(ax) * SQ_W'(ax);
      sqy <= SQ_W'(ay) * SQ_W'(ay);
    end
    if (state == S_SUM) begin
      rad  <= RAD_W'(sqx) + RAD_W'(sqy);
      rrem <= '0;
      root <= '0;
      rcnt <= '0;
    end
    if (state == S_ROOT) begin
      rad  <= rad << 2;
      rcnt <= rcnt + 1'b1;
      if (rem_sh >= trial) begin
        rrem <= rem_sh - trial;
        root <= {root[LEN_W-2:0], 1'b1};
      end else begin
        rrem <= rem_sh;
        root <= {root[LEN_W-2:0], 1'b0};
      end
    end
    if (state == S_PREP1) begin
      prodx <= PROD_W'(ax) * PROD_W'(first);
      prody <= PROD_W'(ay) * PROD_W'(first);
    end
    if (state == S_PREP2) begin
      prodx <= PROD_W'(ax) * PROD_W'(sp_eff);
      prody <= PROD_W'(ay) * PROD_W'(sp_eff);
    end
    if ((state == S_DIV1) && div_done) begin
      q_x       <= lane_out[0].quot;
      r_x       <= lane_out[0].rem;
      q_y       <= lane_out[1].quot;
      r_y       <= lane_out[1].rem;
      // samples in segment = quotient + 1
      seg_trunc <= lane_out[2].quot >= LEN_W'(MAX_SEG);
      emit_n    <= (lane_out[2].quot >= LEN_W'(MAX_SEG - 1)) ? CNT_W'(MAX_SEG)
                 : CNT_W'(lane_out[2].quot) + 1'b1;
      k         <= '0;
    end
    if ((state == S_DIV2) && div_done) begin
      sq_x <= lane_out[0].quot;
      sr_x <= lane_out[0].rem;
      sq_y <= lane_out[1].quot;
      sr_y <= lane_out[1].rem;
    end
    if (place) begin
      pend_x     <= sat_coord(val_x);
      pend_y     <= sat_coord(val_y);
      pend_trunc <= seg_trunc;
      k          <= k + 1'b1;
      if (rsum_x >= {1'b0, root}) begin
        r_x <= LEN_W'(rsum_x - {1'b0, root});
        q_x <= q_x + sq_x + 1'b1;
      end else begin
        r_x <= rsum_x[LEN_W-1:0];
        q_x <= q_x + sq_x;
      end
      if (rsum_y >= {1'b0, root}) begin
        r_y <= LEN_W'(rsum_y - {1'b0, root});
        q_y <= q_y + sq_y + 1'b1;
      end else begin
        r_y <= rsum_y[LEN_W-1:0];
        q_y <= q_y + sq_y;
      end
    end
    if ((place && pend_valid) || ((state == S_FLUSH) && pend_valid && (!out_valid || out_ready))) begin
      sample_x    <= pend_x;
      sample_y    <= pend_y;
      truncated   <= pend_trunc;
      last_in_run <= (state == S_FLUSH);
    end
  end

endmodule

// ===== sv/polyline_arc_length_resampler_unit.sv =====
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_unit: equal arc-length polyline resampler
// Places centred samples at a fixed arc-length spacing along a vertex stream.
// ----------------------------------------------------------------------------
// A vertex is taken in one transfer and turned by the front end into a start
// point or a segment command, plus a closing segment command when the vertex
// closes its subpath, queued four deep. The back end handles one command at
// a time: a start point goes straight to emission; a segment is popped,
// squared and summed, its square root taken two bits a cycle, and set up
// by two passes of the three-lane divider (launch, 25 quotient bits,
// result); then it emits one sample per cycle unless the output stalls,
// at most 31 samples per segment. The square root and the divider set the
// per-segment cost; the output count sets the rest. The last sample of a
// vertex is held until its last command ends so that last_in_run marks it.
// Configuration writes land at once; change them only while idle.
module polyline_arc_length_resampler_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [plar_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [plar_pkg::COORD_W-1:0]  vertex_y,
  input  logic                                 starts_subpath,
  input  logic                                 closes_subpath,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [plar_pkg::COORD_W-1:0]  sample_x,
  output logic signed [plar_pkg::COORD_W-1:0]  sample_y,
  output logic                                 last_in_run,
  output logic                                 truncated,
  input  logic                                 cfg_write,
  input  logic [plar_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [plar_pkg::COORD_W-1:0]         cfg_data
);
  import plar_pkg::*;

  logic [SPACE_W-1:0]        spacing;
  logic signed [COORD_W-1:0] centre_x, centre_y;
  logic                      q_push, q_pop, q_full, q_empty;
  cmd_t                      push_cmd, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing  <= SPACING_RESET;
      centre_x <= '0;
      centre_y <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPACING:  spacing  <= cfg_data[SPACE_W-1:0];
        REG_CENTRE_X: centre_x <= cfg_data;
        REG_CENTRE_Y: centre_y <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // intake: classify the vertex into commands
  plar_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .vertex_x       (vertex_x),
    .vertex_y       (vertex_y),
    .starts_subpath (starts_subpath),
    .closes_subpath (closes_subpath),
    .push           (q_push),
    .push_cmd       (push_cmd),
    .q_full         (q_full)
  );

  // decouple intake from sampling
  plar_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // measure, divide and walk each segment
  plar_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .spacing     (spacing),
    .centre_x    (centre_x),
    .centre_y    (centre_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .last_in_run (last_in_run),
    .truncated   (truncated)
  );

  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // never read an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  // a taken vertex occupies the intake for at least the next cycle
  a_intake_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("intake ready right after a transfer");

endmodule
